// ===== sv/pgwalk_pkg.sv =====
// shared types and constants of the four-level page table walker
// no dependencies; imported by pgwalk_tbl_ram, four_level_page_table_walker_unit and the testbench
package pgwalk_pkg;

  // table geometry and field widths
  localparam int unsigned ENTRIES_PER_TABLE = 512;
  localparam int unsigned IDX_W             = 9;
  localparam int unsigned ENTRY_W           = 64;
  localparam int unsigned VA_W              = 48;
  localparam int unsigned PA_W              = 52;
  localparam int unsigned FRAME_W           = 40;
  localparam int unsigned SLOT_IN_W         = 3;
  localparam int unsigned KIND_W            = 2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_SLOT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 1'd1;

  // item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_XLATE = 1'b1;

  // page kinds
  localparam logic [KIND_W-1:0] KIND_4K = 2'd0;
  localparam logic [KIND_W-1:0] KIND_2M = 2'd1;
  localparam logic [KIND_W-1:0] KIND_1G = 2'd2;

  // entry flag bits
  localparam int unsigned BIT_PRESENT = 0;
  localparam int unsigned BIT_LARGE   = 7;

  // port widths
  localparam int unsigned S_TDATA_W = 128;
  localparam int unsigned M_TDATA_W = 56;

  // table memory request
  typedef struct packed {
    logic wr;
    logic rd;
  } ram_req_t;

endpackage

// ===== sv/pgwalk_tbl_ram.sv =====
// table store: single-port-write, registered-read memory with a zeroing sweep after reset
// depends on pgwalk_pkg
module pgwalk_tbl_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pgwalk_pkg::ram_req_t        req_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [pgwalk_pkg::ENTRY_W-1:0] wr_data_i,
  input  logic [AW-1:0]               rd_addr_i,
  output logic [pgwalk_pkg::ENTRY_W-1:0] rd_data_o,
  output logic                        clr_busy_o
);
  import pgwalk_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data_q;
  logic               clr_busy_q, clr_busy_d;
  logic [AW-1:0]      clr_addr_q, clr_addr_d;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // zeroing sweep owns the write port until done
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (req_i.wr) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_busy_q;

endmodule

// ===== sv/four_level_page_table_walker_unit.sv =====
// four-level page table walker: table store writes and 48-bit address translation
// depends on pgwalk_pkg and pgwalk_tbl_ram
//
// channel   direction  fields (low bit first)
// s_axis    in         tuser: mode; tdata: slot, entry_index, entry_value, virtual_address
// m_axis    out        tdata: physical_address, mapped; tuser: page_kind
// cfg       in         cfg_we_i, cfg_idx_i (0 root_slot, 1 region_base_frame), cfg_wdata_i
//
// a write item is taken in the idle state; a translate item issues the top-level read
// and then walks one level at a time, each level waiting on the registered read of the
// single table memory
// after reset the memory is zeroed, all TABLE_SLOTS * 512 entries (4096 by default),
// with s_axis_tready low; configuration writes are taken meanwhile
// the result register lets the next item in while a result waits; a finished walk
// stalls in place until the result register frees
module four_level_page_table_walker_unit #(
  parameter int unsigned TABLE_SLOTS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input items
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // slot [2:0], entry_index [11:3], entry_value [75:12], virtual_address [123:76]
  input  logic [pgwalk_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // mode [0]
  input  logic                               s_axis_tuser,
  // result items
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // physical_address [51:0], mapped [52]
  output logic [pgwalk_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // page_kind [1:0]
  output logic [pgwalk_pkg::KIND_W-1:0]      m_axis_tuser,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [pgwalk_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pgwalk_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import pgwalk_pkg::*;

  localparam int unsigned SLOT_W = $clog2(TABLE_SLOTS);
  localparam int unsigned AW     = SLOT_W + IDX_W;
  localparam int unsigned DEPTH  = TABLE_SLOTS * ENTRIES_PER_TABLE;

  // walker states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  // input fields
  logic [SLOT_IN_W-1:0] in_slot;
  logic [IDX_W-1:0]     in_idx;
  logic [ENTRY_W-1:0]   in_entry;
  logic [VA_W-1:0]      in_va;
  logic                 in_mode;

  assign in_slot  = s_axis_tdata[2:0];
  assign in_idx   = s_axis_tdata[11:3];
  assign in_entry = s_axis_tdata[75:12];
  assign in_va    = s_axis_tdata[123:76];
  assign in_mode  = s_axis_tuser;

  // configuration
  logic [SLOT_IN_W-1:0] root_slot_q;
  logic [FRAME_W-1:0]   base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_slot_q <= '0;
      base_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROOT_SLOT:   root_slot_q <= cfg_wdata_i[SLOT_IN_W-1:0];
        CFG_REGION_BASE: base_q      <= cfg_wdata_i[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // walker state
  logic            state_q, state_d;
  logic [1:0]      lvl_q, lvl_d;
  logic            fault_q, fault_d;
  logic [VA_W-1:0] va_q, va_d;

  // result register
  logic              m_valid_q, m_valid_d;
  logic [PA_W-1:0]   m_pa_q, m_pa_d;
  logic              m_mapped_q, m_mapped_d;
  logic [KIND_W-1:0] m_kind_q, m_kind_d;

  // memory interface
  ram_req_t           ram_req;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic [ENTRY_W-1:0] entry;
  logic               clr_busy;

  pgwalk_tbl_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_tbl_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (ram_req),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (in_entry),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (entry),
    .clr_busy_o (clr_busy)
  );

  // per-level evaluation of the entry just read
  logic               in_fire;
  logic               slot_ok;
  logic               root_ok;
  logic               out_free;
  logic [FRAME_W:0]   frame_diff;
  logic               frame_ok;
  logic [IDX_W-1:0]   nxt_idx;
  logic               done;
  logic [PA_W-1:0]    res_pa;
  logic               res_mapped;
  logic [KIND_W-1:0]  res_kind;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign slot_ok  = 32'(in_slot) < TABLE_SLOTS;
  assign root_ok  = 32'(root_slot_q) < TABLE_SLOTS;
  assign out_free = !m_valid_q || m_axis_tready;

  // table pointer maps to a slot only inside [base, base + TABLE_SLOTS)
  assign frame_diff = {1'b0, entry[51:12]} - {1'b0, base_q};
  assign frame_ok   = !frame_diff[FRAME_W] && (frame_diff[FRAME_W-1:0] < FRAME_W'(TABLE_SLOTS));

  always_comb begin
    case (lvl_q)
      2'd0:    nxt_idx = va_q[38:30];
      2'd1:    nxt_idx = va_q[29:21];
      default: nxt_idx = va_q[20:12];
    endcase
  end

  always_comb begin
    done       = 1'b1;
    res_pa     = '0;
    res_mapped = 1'b0;
    res_kind   = KIND_4K;
    if (fault_q || !entry[BIT_PRESENT]) begin
      done = 1'b1;
    end else if (lvl_q == 2'd1 && entry[BIT_LARGE]) begin
      res_pa     = {entry[51:30], va_q[29:0]};
      res_mapped = 1'b1;
      res_kind   = KIND_1G;
    end else if (lvl_q == 2'd2 && entry[BIT_LARGE]) begin
      res_pa     = {entry[51:21], va_q[20:0]};
      res_mapped = 1'b1;
      res_kind   = KIND_2M;
    end else if (lvl_q == 2'd3) begin
      res_pa     = {entry[51:12], va_q[11:0]};
      res_mapped = 1'b1;
      res_kind   = KIND_4K;
    end else if (!frame_ok) begin
      done = 1'b1;
    end else begin
      done = 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    lvl_d      = lvl_q;
    fault_d    = fault_q;
    va_d       = va_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_pa_d     = m_pa_q;
    m_mapped_d = m_mapped_q;
    m_kind_d   = m_kind_q;
    ram_req    = '0;
    wr_addr    = {SLOT_W'(in_slot), in_idx};
    rd_addr    = {SLOT_W'(root_slot_q), in_va[47:39]};
    s_axis_tready = (state_q == ST_IDLE) && !clr_busy;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_mode == MODE_WRITE) begin
            // writes to a slot past the store are dropped
            ram_req.wr = slot_ok;
          end else begin
            ram_req.rd = root_ok;
            va_d       = in_va;
            lvl_d      = 2'd0;
            fault_d    = !root_ok;
            state_d    = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        rd_addr = {frame_diff[SLOT_W-1:0], nxt_idx};
        if (!done) begin
          ram_req.rd = 1'b1;
          lvl_d      = lvl_q + 2'd1;
        end else if (out_free) begin
          // read data holds until the result is taken into the output register
          m_valid_d  = 1'b1;
          m_pa_d     = res_pa;
          m_mapped_d = res_mapped;
          m_kind_d   = res_kind;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q      <= lvl_d;
    fault_q    <= fault_d;
    va_q       <= va_d;
    m_pa_q     <= m_pa_d;
    m_mapped_q <= m_mapped_d;
    m_kind_q   <= m_kind_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, m_mapped_q, m_pa_q};
  assign m_axis_tuser  = m_kind_q;

endmodule

// ===== tb/sv/pgwalk_tb_pkg.sv =====
// translation checker for the page table walker testbench: a copy of the table
// store, the walk itself and the queue of translations still owed by the block
// depends on pgwalk_pkg
package pgwalk_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import pgwalk_pkg::*;

  localparam int unsigned WALK_SLOTS     = 8;
  localparam int unsigned SHOWN_FAILURES = 30;

  typedef struct packed {
    logic [PA_W-1:0]   pa;
    logic              mapped;
    logic [KIND_W-1:0] kind;
  } xlate_result_t;

  class walk_checker;
    bit [ENTRY_W-1:0]   table_copy [WALK_SLOTS*ENTRIES_PER_TABLE];
    logic [2:0]         root_slot;
    logic [FRAME_W-1:0] region_base;
    xlate_result_t      expected_xlates [$];
    int unsigned        n_writes, n_walks, n_4k, n_2m, n_1g, n_faults, failures;

    function new();
      root_slot   = '0;
      region_base = '0;
    endfunction

    function void set_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ROOT_SLOT: begin
          root_slot = data[2:0];
        end
        CFG_REGION_BASE: begin
          region_base = data;
        end
        default: begin
        end
      endcase
    endfunction

    function bit [ENTRY_W-1:0] entry_at(int unsigned s, logic [IDX_W-1:0] ix);
      return table_copy[s*ENTRIES_PER_TABLE + 32'(ix)];
    endfunction

    // frame of a table pointer to slot number, 0 when outside the region
    function bit frame_slot(logic [ENTRY_W-1:0] e, output int unsigned s);
      logic [FRAME_W-1:0] fr;
      fr = e[51:12];
      s  = 0;
      if (fr < region_base) return 1'b0;
      if (fr - region_base >= 40'(WALK_SLOTS)) return 1'b0;
      s = 32'(fr - region_base);
      return 1'b1;
    endfunction

    function xlate_result_t walk_address(logic [VA_W-1:0] va);
      xlate_result_t r;
      logic [ENTRY_W-1:0] e;
      int unsigned s;
      r = '0;
      if (32'(root_slot) >= WALK_SLOTS) return r;
      e = entry_at(32'(root_slot), va[47:39]);
      if (!e[BIT_PRESENT] || !frame_slot(e, s)) return r;
      e = entry_at(s, va[38:30]);
      if (!e[BIT_PRESENT]) return r;
      if (e[BIT_LARGE]) begin
        r.pa = {e[51:30], va[29:0]};
        r.mapped = 1'b1;
        r.kind = KIND_1G;
        return r;
      end
      if (!frame_slot(e, s)) return r;
      e = entry_at(s, va[29:21]);
      if (!e[BIT_PRESENT]) return r;
      if (e[BIT_LARGE]) begin
        r.pa = {e[51:21], va[20:0]};
        r.mapped = 1'b1;
        r.kind = KIND_2M;
        return r;
      end
      if (!frame_slot(e, s)) return r;
      e = entry_at(s, va[20:12]);
      if (!e[BIT_PRESENT]) return r;
      r.pa = {e[51:12], va[11:0]};
      r.mapped = 1'b1;
      r.kind = KIND_4K;
      return r;
    endfunction

    function void note_item(logic mode, logic [2:0] slot, logic [IDX_W-1:0] ix,
                            logic [ENTRY_W-1:0] val, logic [VA_W-1:0] va);
      xlate_result_t r;
      if (mode == MODE_WRITE) begin
        n_writes++;
        if (32'(slot) < WALK_SLOTS) table_copy[32'(slot)*ENTRIES_PER_TABLE + 32'(ix)] = val;
        return;
      end
      r = walk_address(va);
      n_walks++;
      if (!r.mapped) n_faults++;
      else if (r.kind == KIND_4K) n_4k++;
      else if (r.kind == KIND_2M) n_2m++;
      else n_1g++;
      expected_xlates.push_back(r);
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      failures++;
      if (failures <= SHOWN_FAILURES)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    endfunction

    function void check_result(xlate_result_t got);
      xlate_result_t want;
      if (expected_xlates.size() == 0) begin
        failures++;
        if (failures <= SHOWN_FAILURES)
          $display("%0t: result with no translation pending, expected none, got pa 0x%0h",
                   $time, got.pa);
        return;
      end
      want = expected_xlates.pop_front();
      if (got.pa !== want.pa) flag("physical_address", 64'(want.pa), 64'(got.pa));
      if (got.mapped !== want.mapped) flag("mapped", 64'(want.mapped), 64'(got.mapped));
      if (got.kind !== want.kind) flag("page_kind", 64'(want.kind), 64'(got.kind));
    endfunction

    function int unsigned pending();
      return expected_xlates.size();
    endfunction

    function void summary(int unsigned settings);
      $display("ran %0d table writes and %0d translations over %0d register settings",
               n_writes, n_walks, settings);
      $display("walks ended in %0d 4 KiB, %0d 2 MiB and %0d 1 GiB pages, %0d faults",
               n_4k, n_2m, n_1g, n_faults);
    endfunction
  endclass

endpackage

// ===== tb/sv/tb.sv =====
// top-level testbench of four_level_page_table_walker_unit: directed and random
// table writes and translations, every result checked against a walk of a table copy
// depends on pgwalk_pkg, pgwalk_tb_pkg and the walker rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pgwalk_pkg::*;
  import pgwalk_tb_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 16;   // settle time before a register write

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;   // slot, entry_index, entry_value, virtual_address
  logic                  s_axis_tuser;   // mode
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;   // physical_address, mapped
  logic [KIND_W-1:0]     m_axis_tuser;   // page_kind
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  walk_checker        walk_sb;
  logic [2:0]         cur_root;
  logic [FRAME_W-1:0] cur_base;
  bit                 quiet;      // no idling on either side while set
  bit                 hold_req;   // asks the receiver for one long hold-off
  int unsigned        items_sent;
  int unsigned        settings;

  four_level_page_table_walker_unit #(
    .TABLE_SLOTS(WALK_SLOTS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // random helpers
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [VA_W-1:0] rand48();
    logic [63:0] v;
    v = rand64();
    return v[VA_W-1:0];
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // table pointer to a frame; flag bits other than present and large are noise
  function automatic logic [63:0] make_ptr(logic [FRAME_W-1:0] frame, bit big_page);
    logic [63:0] e;
    e = rand64();
    e[51:12] = frame;
    e[BIT_PRESENT] = 1'b1;
    e[BIT_LARGE] = big_page;
    return e;
  endfunction

  // final mapping entry with a random frame
  function automatic logic [63:0] make_leaf(bit big_page);
    logic [63:0] e;
    e = rand64();
    e[BIT_PRESENT] = 1'b1;
    e[BIT_LARGE] = big_page;
    return e;
  endfunction

  // breaks one link of a chain: not present, or frame outside the region
  function automatic logic [63:0] spoil(logic [63:0] e);
    case ($urandom_range(0, 2))
      0: begin
        e[BIT_PRESENT] = 1'b0;
      end
      1: begin
        e[51:12] = cur_base - 40'($urandom_range(1, 1000));
      end
      default: begin
        e[51:12] = cur_base + 40'($urandom_range(WALK_SLOTS, 1000));
      end
    endcase
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one item on the input stream; the checker notes it at its handshake
  task automatic offer(logic mode, logic [2:0] slot, logic [IDX_W-1:0] ix,
                       logic [ENTRY_W-1:0] val, logic [VA_W-1:0] va);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {4'b0, va, val, ix, slot};
    do @(posedge clk_i); while (!s_axis_tready);
    walk_sb.note_item(mode, slot, ix, val, va);
    items_sent++;
  endtask

  // unused fields of an item carry random junk
  task automatic write_entry(logic [2:0] slot, logic [IDX_W-1:0] ix, logic [ENTRY_W-1:0] val);
    offer(MODE_WRITE, slot, ix, val, rand48());
  endtask

  task automatic translate(logic [VA_W-1:0] va);
    offer(MODE_XLATE, 3'($urandom_range(0, 7)), 9'($urandom_range(0, 511)), rand64(), va);
  endtask

  task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    walk_sb.set_cfg(idx, val);
  endtask

  // both registers, only while nothing is in flight
  task automatic configure(logic [2:0] root, logic [FRAME_W-1:0] base);
    set_register(CFG_ROOT_SLOT, {37'd0, root});
    set_register(CFG_REGION_BASE, base);
    cfg_we_i <= 1'b0;
    cur_root = root;
    cur_base = base;
    settings++;
  endtask

  // stop offering, wait for every owed result, then let a trailing write settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (walk_sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // builds a well-formed walk for a random address ending in a page of random
  // size, sometimes with one broken link, then translates into it
  task automatic build_and_walk();
    logic [VA_W-1:0]    va;
    logic [63:0]        e;
    logic [2:0]         s_cur, s_next;
    logic [IDX_W-1:0]   ix;
    int unsigned        levels, bad, lv;
    va     = rand48();
    levels = $urandom_range(2, 4);   // 2 ends at 1 GiB, 3 at 2 MiB, 4 at 4 KiB
    bad    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, levels) : 0;
    s_cur  = cur_root;
    s_next = '0;
    for (lv = 1; lv <= levels; lv++) begin
      ix = va[47-9*(lv-1) -: 9];
      if (lv < levels) begin
        s_next = 3'($urandom_range(0, 7));
        // large bit of a top-level pointer is don't-care
        e = make_ptr(cur_base + 40'(s_next), (lv == 1) ? 1'($urandom_range(0, 1)) : 1'b0);
      end else begin
        // large bit of a last-level entry is don't-care
        e = make_leaf((lv == 4) ? 1'($urandom_range(0, 1)) : 1'b1);
      end
      if (lv == bad) e = spoil(e);
      write_entry(s_cur, ix, e);
      s_cur = s_next;
    end
    translate(va);
    if ($urandom_range(0, 1) == 1) translate({va[47:12], 12'($urandom_range(0, 4095))});
  endtask

  task automatic run_phase(logic [2:0] root, logic [FRAME_W-1:0] base, int unsigned n,
                           bit calm, bit squeeze);
    int unsigned first, r;
    configure(root, base);
    quiet = calm;
    if (squeeze) hold_req = 1'b1;
    first = items_sent;
    while (items_sent - first < n) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        build_and_walk();
      end else if (r < 85) begin
        translate(rand48());
      end else begin
        write_entry(3'($urandom_range(0, 7)), 9'($urandom_range(0, 511)), rand64());
      end
    end
    drain();
    quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random ready with one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned gap;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        // long hold-off so the walker fills up and stalls its input
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        gap = idle_len();
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // every accepted result is checked against the oldest owed translation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      walk_sb.check_result({m_axis_tdata[PA_W-1:0], m_axis_tdata[PA_W], m_axis_tuser});
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic [FRAME_W-1:0] b;
    walk_sb       = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_WRITE;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_ROOT_SLOT;
    cfg_wdata_i   = '0;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    items_sent    = 0;
    settings      = 0;
    cur_root      = '0;
    cur_base      = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: registers go in while the store is still clearing
    b = 40'h01_2345_6780;
    configure(3'd3, b);
    translate(48'h0);                                        // empty store faults
    write_entry(3'd3, 9'd5, make_ptr(b + 40'd1, 1'b1));      // top large bit ignored
    write_entry(3'd1, 9'd7, make_ptr(b + 40'd2, 1'b0));
    write_entry(3'd2, 9'd9, make_ptr(b + 40'd4, 1'b0));
    write_entry(3'd4, 9'd11, 64'hffff_ffff_ffff_ffff);       // 4k leaf, large bit ignored
    translate({9'd5, 9'd7, 9'd9, 9'd11, 12'hfff});
    write_entry(3'd1, 9'd8, make_leaf(1'b1));                // 1g page
    translate({9'd5, 9'd8, 30'h1555_5555});
    write_entry(3'd2, 9'd10, make_leaf(1'b1));               // 2m page
    translate({9'd5, 9'd7, 9'd10, 21'h1f_ffff});
    write_entry(3'd1, 9'd20, make_ptr(b - 40'd1, 1'b0));     // just below the region
    translate({9'd5, 9'd20, 30'h0});
    write_entry(3'd1, 9'd21, make_ptr(b + 40'(WALK_SLOTS), 1'b0));  // just past it
    translate({9'd5, 9'd21, 30'h0});
    write_entry(3'd2, 9'd12, 64'hffff_ffff_ffff_fffe);       // every bit but present
    translate({9'd5, 9'd7, 9'd12, 21'h0});
    translate({9'd5, 9'd7, 9'd9, 9'd12, 12'h0});             // last level never written
    // walk of the all-ones address through the highest index everywhere
    write_entry(3'd3, 9'd511, make_ptr(b + 40'd7, 1'b0));
    write_entry(3'd7, 9'd511, make_ptr(b, 1'b0));
    write_entry(3'd0, 9'd511, make_ptr(b + 40'd6, 1'b0));
    write_entry(3'd6, 9'd511, make_leaf(1'b0));
    translate(48'hffff_ffff_ffff);
    write_entry(3'd0, 9'd0, 64'h0);
    translate(48'h0);
    drain();

    // random phases: register extremes first, then random settings
    run_phase(3'd0, 40'h0, 240, 1'b0, 1'b0);
    run_phase(3'd7, 40'hff_ffff_ffff, 200, 1'b1, 1'b0);   // only slot zero reachable
    run_phase(3'd7, 40'hff_ffff_fff8, 240, 1'b0, 1'b1);   // region ends at the top frame
    run_phase(3'($urandom_range(0, 7)), 40'(rand64()), 250, 1'b0, 1'b0);
    run_phase(3'($urandom_range(0, 7)), 40'(rand64()), 250, 1'b0, 1'b1);
    run_phase(3'($urandom_range(0, 7)), 40'(rand64()), 250, 1'b0, 1'b0);

    walk_sb.summary(settings);
    if (walk_sb.failures == 0) begin
      $display("four_level_page_table_walker_unit regression: pass");
    end else begin
      $display("four_level_page_table_walker_unit regression: fail");
    end
    $finish;
  end

  // run limit: clearing pass plus a slow run, several times over
  initial begin
    #12ms;
    $display("four_level_page_table_walker_unit regression: fail");
    $finish;
  end

endmodule
